// File: rtl/hsk_pkg.sv
package hsk_pkg;

    localparam int DEPTH = 64;
    localparam int KW    = 32;
    localparam int PW    = 32;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    typedef struct packed {
        logic signed [KW-1:0] key;
        logic        [PW-1:0] payload;
        logic                 last_item;
    } in_item_t;

    typedef struct packed {
        logic signed [KW-1:0] sorted_key;
        logic        [PW-1:0] sorted_payload;
        logic                 overflowed;
        logic                 last_result;
    } out_item_t;

    // one stored pair
    typedef struct packed {
        logic signed [KW-1:0] key;
        logic        [PW-1:0] payload;
    } entry_t;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_TOP      = 7'b0000010,
        ST_LOAD     = 7'b0000100,
        ST_SIFT_RD  = 7'b0001000,
        ST_SIFT_CMP = 7'b0010000,
        ST_FINAL    = 7'b0100000,
        ST_OUT      = 7'b1000000
    } state_t;

    function automatic logic key_less(input logic signed [KW-1:0] a,
                                      input logic signed [KW-1:0] b);
        return a < b;
    endfunction

endpackage

// File: rtl/heap_sort_key_payload_top.sv
// Heapsort of a run of (signed key, payload) requests. Each request is taken
// when start is high and busy is low; a request is stored as it is taken and the
// block stays ready until the request marked last_item arrives. Then busy rises
// and the run is sorted in place by ascending key with an in-place heapsort
// (build a max-heap, then move the root to the end), so equal keys leave in
// that heapsort's order. The sort runs on one dual-read, single-write pair
// store and two key compare paths. A heap step fetches the element being
// placed, then per sift level reads both children and then compares and writes
// back, with a final write when the sift runs past the end of the heap.
// A run of n pairs needs n/2 build steps and n - 1 extract steps. The final
// state then places the last root, and the emit phase sends the run out, one
// result per cycle on result_strobe with result.last_result on the final
// one; a run of a single pair skips the sort. Results cannot be held off by
// the receiver: each is valid for exactly one cycle. Requests beyond DEPTH
// pairs are dropped and every result of that run carries result.overflowed.
// Busy falls while the last result is on the ports, so the first request of
// the next run can be taken at the edge that ends it.
module heap_sort_key_payload_top
    import hsk_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  item,
    output logic      busy,
    output logic      result_strobe,
    output out_item_t result
);

    // pair store
    entry_t mem [DEPTH];

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           ovf_reg, ovf_next;
    logic [AW-1:0]  left_reg, left_next;
    logic [AW-1:0]  hi_reg, hi_next;
    logic [AW-1:0]  pos_reg, pos_next;
    logic [AW:0]    child_reg, child_next;
    logic           extract_reg, extract_next;
    logic [AW-1:0]  out_idx_reg, out_idx_next;
    entry_t         hk_reg, hk_next;
    logic           strobe_reg, strobe_next;
    logic           res_last_reg, res_last_next;
    logic           res_ovf_reg, res_ovf_next;
    entry_t         rd_a_reg, rd_b_reg;

    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    entry_t         wr_data;
    logic [AW-1:0]  rd_a_addr, rd_b_addr;
    logic [CW-1:0]  n_new;
    logic           take_b;
    entry_t         sel;
    logic [AW-1:0]  sel_idx;
    logic [AW:0]    hi_ext;

    assign hi_ext = {1'b0, hi_reg};

    // larger child and its index
    always_comb
    begin
        take_b  = (hi_ext > child_reg) && key_less(rd_a_reg.key, rd_b_reg.key);
        sel     = take_b ? rd_b_reg : rd_a_reg;
        sel_idx = take_b ? child_reg[AW-1:0] + 1'b1 : child_reg[AW-1:0];
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        left_next     = left_reg;
        hi_next       = hi_reg;
        pos_next      = pos_reg;
        child_next    = child_reg;
        extract_next  = extract_reg;
        out_idx_next  = out_idx_reg;
        hk_next       = hk_reg;
        strobe_next   = 1'b0;
        res_last_next = res_last_reg;
        res_ovf_next  = res_ovf_reg;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = hk_reg;
        rd_a_addr     = '0;
        rd_b_addr     = '0;
        n_new         = count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // store while room remains, else drop and flag
                    if (count_reg != CW'(DEPTH))
                    begin
                        wr_en   = 1'b1;
                        wr_addr = count_reg[AW-1:0];
                        wr_data = '{key: item.key, payload: item.payload};
                        n_new   = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    count_next = n_new;
                    if (item.last_item)
                    begin
                        out_idx_next = '0;
                        left_next    = AW'(n_new >> 1);
                        hi_next      = AW'(n_new - 1'b1);
                        if (n_new >= CW'(2))
                            state_next = ST_TOP;
                        else
                            state_next = ST_OUT;
                    end
                end
            end

            ST_TOP:
            begin
                // heap build step, or move root to the end
                if (left_reg != '0)
                begin
                    left_next    = left_reg - 1'b1;
                    rd_a_addr    = left_reg - 1'b1;
                    extract_next = 1'b0;
                end
                else
                begin
                    rd_a_addr    = hi_reg;
                    rd_b_addr    = '0;
                    extract_next = 1'b1;
                end
                state_next = ST_LOAD;
            end

            ST_LOAD:
            begin
                hk_next = rd_a_reg;
                if (extract_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = hi_reg;
                    wr_data = rd_b_reg;
                    hi_next = hi_reg - 1'b1;
                    if (hi_reg == AW'(1))
                    begin
                        state_next = ST_FINAL;
                    end
                    else
                    begin
                        pos_next   = '0;
                        child_next = (AW+1)'(1);
                        state_next = ST_SIFT_RD;
                    end
                end
                else
                begin
                    pos_next   = left_reg;
                    child_next = {left_reg, 1'b1};
                    state_next = ST_SIFT_RD;
                end
            end

            ST_SIFT_RD:
            begin
                if (hi_ext >= child_reg)
                begin
                    rd_a_addr  = child_reg[AW-1:0];
                    rd_b_addr  = child_reg[AW-1:0] + 1'b1;
                    state_next = ST_SIFT_CMP;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg;
                    wr_data    = hk_reg;
                    state_next = ST_TOP;
                end
            end

            ST_SIFT_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                if (key_less(hk_reg.key, sel.key))
                begin
                    // promote child, descend
                    wr_data    = sel;
                    pos_next   = sel_idx;
                    child_next = {sel_idx, 1'b1};
                    state_next = ST_SIFT_RD;
                end
                else
                begin
                    wr_data    = hk_reg;
                    state_next = ST_TOP;
                end
            end

            ST_FINAL:
            begin
                wr_en        = 1'b1;
                wr_addr      = '0;
                wr_data      = hk_reg;
                out_idx_next = '0;
                state_next   = ST_OUT;
            end

            ST_OUT:
            begin
                // issue one read per cycle, result follows from the registered read in the next cycle
                rd_a_addr     = out_idx_reg;
                strobe_next   = 1'b1;
                res_ovf_next  = ovf_reg;
                res_last_next = (CW'(out_idx_reg) + 1'b1 == count_reg);
                if (res_last_next)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    out_idx_next = out_idx_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            strobe_reg <= strobe_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        left_reg     <= left_next;
        hi_reg       <= hi_next;
        pos_reg      <= pos_next;
        child_reg    <= child_next;
        extract_reg  <= extract_next;
        out_idx_reg  <= out_idx_next;
        hk_reg       <= hk_next;
        res_last_reg <= res_last_next;
        res_ovf_reg  <= res_ovf_next;
    end

    // store: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_a_reg <= mem[rd_a_addr];
        rd_b_reg <= mem[rd_b_addr];
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_strobe = strobe_reg;
    assign result        = '{sorted_key:     rd_a_reg.key,
                             sorted_payload: rd_a_reg.payload,
                             overflowed:     res_ovf_reg,
                             last_result:    res_last_reg};

    // results only come out of the emit phase
    a_strobe_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(state_reg == ST_OUT))
        else $error("result strobe without emit phase");

    // the final result closes the run
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last_result) |-> (state_reg == ST_IDLE))
        else $error("block still busy after last result");

    // a child compare only runs on a child inside the heap
    a_child_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SIFT_CMP) |-> (hi_ext >= child_reg))
        else $error("sift compare beyond heap end");

    // fill count never passes the store size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count beyond store size");

    // the sort only starts on a run of two or more pairs
    a_sort_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TOP) |-> (count_reg >= CW'(2)))
        else $error("sort started on a run shorter than two");

endmodule
